// ===== design/midi_message_parser_top_defines.svh =====
// Assertion macros for the MIDI message parser.
`ifndef MIDI_MESSAGE_PARSER_TOP_DEFINES_SVH
`define MIDI_MESSAGE_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define MMP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmp: implication check failed");

`define MMP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmp: next-cycle check failed");

`else

`define MMP_ASSERT_IMP(label, ante, cons)

`define MMP_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== design/mmp_pkg.sv =====
// Types and constants shared by the MIDI message parser.
package mmp_pkg;

	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_START    = 3'd1;
	localparam logic [2:0] KIND_CONTINUE = 3'd2;
	localparam logic [2:0] KIND_STOP     = 3'd3;
	localparam logic [2:0] KIND_CHANNEL  = 3'd4;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_DATA1 = 2'd1;
	localparam logic [1:0] PH_DATA2 = 2'd2;

	localparam logic [7:0] ST_CLOCK    = 8'hF8;
	localparam logic [7:0] ST_START    = 8'hFA;
	localparam logic [7:0] ST_CONTINUE = 8'hFB;
	localparam logic [7:0] ST_STOP     = 8'hFC;

	localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
	localparam logic [3:0] HI_NOTE_ON   = 4'h9;
	localparam logic [3:0] HI_CTRL      = 4'hB;
	localparam logic [3:0] HI_PROGRAM   = 4'hC;
	localparam logic [3:0] HI_CH_PRESS  = 4'hD;
	localparam logic [3:0] HI_SYSTEM    = 4'hF;
	localparam logic [3:0] CHAN_MASK    = 4'hF;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] status_byte;
		logic [4:0] channel_number;
		logic [6:0] first_data;
		logic [6:0] second_data;
	} event_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       running;
	} parse_stat_t;

endpackage

// ===== design/mmp_stream_if.sv =====
// Valid/ready stream channel used for both the byte and the event side.
interface mmp_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/midi_message_parser_top.sv =====
// MIDI message parser: received bytes in, transport and channel events out.
//
// rx carries one MIDI byte per beat; evt carries one event per beat
// (kind, status, channel 1..16, two data fields). Both are valid/ready.
// Each accepted byte yields zero or one event. An event appears on evt in
// the cycle after its byte is accepted, from a single result register.
// Throughput is one byte per cycle: rx.ready is high whenever the result
// register is empty or its event is being taken in the same cycle.
// When the receiver stalls with an event held, rx.ready drops until the
// event is taken; nothing is lost or repeated. Bytes that give no event
// still need the result register free, since the register's next
// contents are decided at the accept edge.
// Reset (arst_n low) clears the parse phase, pending status, held data, the
// transport-running flag and result valid bit, not event data; no clearing pass.
`include "midi_message_parser_top_defines.svh"

module midi_message_parser_top
	import mmp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mmp_stream_if.sink   rx,
	mmp_stream_if.source evt
);

	logic        acc;
	logic        room;
	logic        ev_valid;
	event_t      ev;
	parse_stat_t stat;

	assign rx.ready = room;
	assign acc      = rx.valid && room;

	mmp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.rx_byte  (rx.data),
		.ev_valid (ev_valid),
		.ev       (ev),
		.stat     (stat)
	);

	mmp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (acc),
		.ev_valid (ev_valid),
		.ev       (ev),
		.room     (room),
		.evt      (evt)
	);

	`MMP_ASSERT_IMP(a_stall_blocks_rx, evt.valid && !evt.ready, !rx.ready)
	`MMP_ASSERT_NXT(a_realtime_idles, acc && rx.data >= ST_CLOCK, stat.phase == PH_IDLE)
	`MMP_ASSERT_NXT(a_start_runs, acc && rx.data == ST_START, evt.valid && stat.running)
	`MMP_ASSERT_IMP(a_chan_nonzero, evt.valid && evt.data.event_kind == KIND_CHANNEL, evt.data.channel_number != 5'd0)

endmodule

// ===== design/mmp_parser.sv =====
// Parse state registers and the per-byte decode of a MIDI byte.
module mmp_parser
	import mmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [7:0]  rx_byte,
	output logic        ev_valid,
	output event_t      ev,
	output parse_stat_t stat
);

	logic [1:0] phase_q, phase_d;
	logic [7:0] pend_q, pend_d;
	logic [6:0] held_q, held_d;
	logic       run_q, run_d;

	logic [3:0] pend_hi;
	logic [4:0] chan;

	assign pend_hi = pend_q[7:4];
	assign chan    = {1'b0, pend_q[3:0] & CHAN_MASK} + 5'd1;

	always_comb begin
		phase_d  = phase_q;
		pend_d   = pend_q;
		held_d   = held_q;
		run_d    = run_q;
		ev_valid = 1'b0;
		ev       = '0;
		if (rx_byte >= ST_CLOCK) begin
			phase_d = PH_IDLE;
			unique case (rx_byte)
				ST_CLOCK: begin
					ev_valid      = run_q;
					ev.event_kind = KIND_TICK;
				end
				ST_START: begin
					run_d         = 1'b1;
					ev_valid      = 1'b1;
					ev.event_kind = KIND_START;
				end
				ST_CONTINUE: begin
					run_d         = 1'b1;
					ev_valid      = 1'b1;
					ev.event_kind = KIND_CONTINUE;
				end
				ST_STOP: begin
					run_d         = 1'b0;
					ev_valid      = 1'b1;
					ev.event_kind = KIND_STOP;
				end
				default: ;
			endcase
		end else if (rx_byte[7:4] == HI_SYSTEM) begin
			phase_d = PH_IDLE;
		end else if (rx_byte[7]) begin
			pend_d  = rx_byte;
			phase_d = PH_DATA1;
		end else begin
			ev.event_kind     = KIND_CHANNEL;
			ev.status_byte    = pend_q;
			ev.channel_number = chan;
			unique case (phase_q)
				PH_DATA1: begin
					held_d        = rx_byte[6:0];
					ev.first_data = rx_byte[6:0];
					if (pend_hi == HI_PROGRAM || pend_hi == HI_CH_PRESS) begin
						phase_d  = PH_IDLE;
						ev_valid = (pend_hi == HI_PROGRAM);
					end else begin
						phase_d = PH_DATA2;
					end
				end
				PH_DATA2: begin
					phase_d       = PH_IDLE;
					ev.first_data = held_q;
					case (pend_hi) inside
						HI_NOTE_OFF, HI_NOTE_ON, HI_CTRL: begin
							ev_valid       = 1'b1;
							ev.second_data = rx_byte[6:0];
						end
						HI_PROGRAM: ev_valid = 1'b1;
						default: ;
					endcase
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pend_q  <= '0;
			held_q  <= '0;
			run_q   <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			held_q  <= held_d;
			run_q   <= run_d;
		end
	end

	assign stat.phase   = phase_q;
	assign stat.running = run_q;

endmodule

// ===== design/mmp_out_reg.sv =====
// Event result register driving the output channel.
module mmp_out_reg
	import mmp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          ev_valid,
	input  event_t        ev,
	output logic          room,
	mmp_stream_if.source  evt
);

	logic   valid_q;
	event_t data_q;

	assign room = !valid_q || evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= ev_valid;
		end else if (evt.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ev_valid) begin
			data_q <= ev;
		end
	end

	assign evt.valid = valid_q;
	assign evt.data  = data_q;

endmodule
